// ===== rtl/cscan_pkg.sv =====
// Shared types and constants for the C-SCAN request ordering block.
// Used by cscan_ctrl, cscan_dpath and the top level; no dependencies.
`timescale 1ns / 1ps
package cscan_pkg;

  localparam int unsigned MAX_REQUESTS = 64;
  localparam int unsigned TRACK_BITS   = 16;

  // Port field widths
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned MOVE_W  = 18;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int unsigned SUM_W = ((MOVE_W > TRACK_BITS) ? MOVE_W : TRACK_BITS) + 1;

  localparam logic [MOVE_W-1:0] MOVE_MAX = {MOVE_W{1'b1}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_TRACK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_DIR  = 2'd1;

  typedef enum logic [2:0] {
    S_LOAD = 3'b001,
    S_FIND = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  typedef struct packed {
    logic insert;     // take the input item into the sorted chain
    logic find_init;  // start the head search at index 0
    logic find_step;  // advance the head search
    logic emit_init;  // set up the emission pointer and travel sum
    logic emit_step;  // load one result into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic find_done;  // search index sits on the first entry at or above head, or at the fill level
    logic emit_last;  // the next emitted item closes the batch
    logic out_free;   // output register can take a new item this cycle
  } dp_status_t;

endpackage

// ===== rtl/cscan_disk_request_order_unit.sv =====
// Top level of the C-SCAN disk request ordering block.
// Depends on cscan_pkg; instantiates cscan_ctrl and cscan_dpath.
//
// Usage: requests arrive on the input channel (in_valid_i / in_stall_o), one
// track per item, and are inserted into a sorted register chain at one item
// per cycle. The item with batch_end_i set closes the batch. A request that
// arrives with the chain full is dropped, but its batch_end_i still counts.
// After the closing item the block scans the chain from the lowest entry for
// the first track at or above head_track, one entry per step. It then streams
// one served track per cycle, unless out_stall_i holds the output register,
// on the output channel (out_valid_o / out_stall_i) in C-SCAN order;
// the final item has order_end_o set and carries the saturated total travel.
// Input stall is high from the closing item until the final result has been
// loaded into the output register. The output register holds its item while
// out_stall_i is high and emission pauses meanwhile.
// Configuration writes (cfg_we_i, cfg_index_i, cfg_data_i) take effect at the
// next edge: index 0 sets head_track, index 1 sets sweep_direction, others are
// ignored. Reset empties the batch, clears out_valid_o and sets head_track to 0
// and sweep_direction to 1, the ascending sweep.
`timescale 1ns / 1ps
module cscan_disk_request_order_unit
  import cscan_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [FIELD_W-1:0]   request_track_i,
  input  logic                 batch_end_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [FIELD_W-1:0]   served_track_o,
  output logic                 order_end_o,
  output logic [MOVE_W-1:0]    total_movement_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  cscan_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .batch_end_i (batch_end_i),
    .in_stall_o  (in_stall_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cscan_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .request_track_i  (request_track_i),
    .out_stall_i      (out_stall_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (out_valid_o),
    .served_track_o   (served_track_o),
    .order_end_o      (order_end_o),
    .total_movement_o (total_movement_o)
  );

endmodule

// ===== rtl/cscan_ctrl.sv =====
// Sequencer for load, head search and emission phases.
// Depends on cscan_pkg; drives cscan_dpath through ctrl_cmd_t.
`timescale 1ns / 1ps
module cscan_ctrl
  import cscan_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       batch_end_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          cmd_o.insert = 1'b1;
          if (batch_end_i) begin
            cmd_o.find_init = 1'b1;
            state_d         = S_FIND;
          end
        end
      end
      S_FIND: begin
        if (status_i.find_done) begin
          cmd_o.emit_init = 1'b1;
          state_d         = S_EMIT;
        end else begin
          cmd_o.find_step = 1'b1;
        end
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_step = 1'b1;
          if (status_i.emit_last) begin
            state_d = S_LOAD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/cscan_dpath.sv =====
// Sorted insertion chain, head search, emission pointer, travel sum, output register.
// Depends on cscan_pkg; controlled by cscan_ctrl.
`timescale 1ns / 1ps
module cscan_dpath
  import cscan_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [FIELD_W-1:0]   request_track_i,
  input  logic                 out_stall_i,
  input  ctrl_cmd_t            cmd_i,
  output dp_status_t           status_o,
  output logic                 out_valid_o,
  output logic [FIELD_W-1:0]   served_track_o,
  output logic                 order_end_o,
  output logic [MOVE_W-1:0]    total_movement_o
);

  logic [TRACK_BITS-1:0] cell_q [MAX_REQUESTS];
  logic [TRACK_BITS-1:0] cell_d [MAX_REQUESTS];
  logic [MAX_REQUESTS-1:0] gt;

  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      ptr_q, ptr_d;
  logic [CNT_W-1:0]      emit_cnt_q, emit_cnt_d;
  logic [TRACK_BITS-1:0] head_q;
  logic                  dir_q;
  logic [TRACK_BITS-1:0] pos_q, pos_d;
  logic [MOVE_W-1:0]     sum_q, sum_d;

  logic                  out_valid_q;
  logic [FIELD_W-1:0]    out_track_q;
  logic                  out_end_q;
  logic [MOVE_W-1:0]     out_move_q;

  logic [TRACK_BITS-1:0] req_track;
  logic [TRACK_BITS-1:0] rd_track;
  logic [TRACK_BITS-1:0] diff;
  logic [SUM_W-1:0]      sum_ext;
  logic [CNT_W-1:0]      count_m1;
  logic                  full;
  logic                  last;

  assign req_track = TRACK_BITS'(request_track_i);
  assign full      = (count_q == CNT_W'(MAX_REQUESTS));
  assign count_m1  = count_q - CNT_W'(1);
  assign rd_track  = cell_q[ptr_q[IDX_W-1:0]];

  // Entries past the fill level count as greater, so the new track lands at
  // the first slot holding a larger value and everything above moves up one.
  always_comb begin
    for (int i = 0; i < MAX_REQUESTS; i++) begin
      gt[i] = (CNT_W'(i) >= count_q) || (cell_q[i] > req_track);
    end
    for (int i = 0; i < MAX_REQUESTS; i++) begin
      if (!gt[i]) begin
        cell_d[i] = cell_q[i];
      end else if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
        cell_d[i] = cell_q[(i > 0) ? i - 1 : 0];
      end else begin
        cell_d[i] = req_track;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.insert && !full) begin
      for (int i = 0; i < MAX_REQUESTS; i++) begin
        cell_q[i] <= cell_d[i];
      end
    end
  end

  assign diff    = (rd_track > pos_q) ? (rd_track - pos_q) : (pos_q - rd_track);
  assign sum_ext = SUM_W'(sum_q) + SUM_W'(diff);
  assign last    = (emit_cnt_q == count_m1);

  always_comb begin
    count_d    = count_q;
    ptr_d      = ptr_q;
    emit_cnt_d = emit_cnt_q;
    pos_d      = pos_q;
    sum_d      = sum_q;
    if (cmd_i.insert && !full) begin
      count_d = count_q + CNT_W'(1);
    end
    if (cmd_i.find_init) begin
      ptr_d = '0;
    end
    if (cmd_i.find_step) begin
      ptr_d = ptr_q + CNT_W'(1);
    end
    if (cmd_i.emit_init) begin
      // ptr_q is the count of entries below head
      if (dir_q) begin
        ptr_d = (ptr_q == count_q) ? '0 : ptr_q;
      end else begin
        ptr_d = (ptr_q == '0) ? count_m1 : ptr_q - CNT_W'(1);
      end
      emit_cnt_d = '0;
      pos_d      = head_q;
      sum_d      = '0;
    end
    if (cmd_i.emit_step) begin
      if (dir_q) begin
        ptr_d = (ptr_q == count_m1) ? '0 : ptr_q + CNT_W'(1);
      end else begin
        ptr_d = (ptr_q == '0) ? count_m1 : ptr_q - CNT_W'(1);
      end
      emit_cnt_d = emit_cnt_q + CNT_W'(1);
      pos_d      = rd_track;
      sum_d      = (sum_ext > SUM_W'(MOVE_MAX)) ? MOVE_MAX : sum_ext[MOVE_W-1:0];
      if (last) begin
        count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      head_q      <= '0;
      dir_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_HEAD_TRACK) begin
          head_q <= TRACK_BITS'(cfg_data_i);
        end else if (cfg_index_i == CFG_SWEEP_DIR) begin
          dir_q <= cfg_data_i[0];
        end
      end
      if (cmd_i.emit_step) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q      <= ptr_d;
    emit_cnt_q <= emit_cnt_d;
    pos_q      <= pos_d;
    sum_q      <= sum_d;
    if (cmd_i.emit_step) begin
      out_track_q <= FIELD_W'(rd_track);
      out_end_q   <= last;
      out_move_q  <= last ? sum_d : '0;
    end
  end

  assign status_o.find_done = (ptr_q == count_q) || !(rd_track < head_q);
  assign status_o.emit_last = last;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o      = out_valid_q;
  assign served_track_o   = out_track_q;
  assign order_end_o      = out_end_q;
  assign total_movement_o = out_move_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_REQUESTS))
    else $error("request count beyond capacity");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_step && last |=> count_q == '0)
    else $error("batch not cleared after final item");

  a_move_only_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_end_q |-> out_move_q == '0)
    else $error("movement reported on non-final item");

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_init |-> count_q != '0)
    else $error("emission started on empty batch");

  a_find_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.find_step |=> ptr_q <= count_q)
    else $error("head search ran past fill level");

endmodule
